>>> sv/ikl_pkg.sv
`timescale 1ns / 1ps

package ikl_pkg;

    // One source byte of the text stream.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_final;
    } in_item_t;

    // One token as it leaves the block.
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_run;
    } token_t;

    // Up to two tokens produced by one source byte, already packed to the front.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } scan_out_t;

    localparam logic [3:0] KIND_IDENT = 4'd0;
    localparam logic [3:0] KIND_U8    = 4'd1;
    localparam logic [3:0] KIND_S8    = 4'd5;
    localparam logic [3:0] KIND_B8    = 4'd9;
    localparam logic [3:0] KIND_F32   = 4'd13;
    localparam logic [3:0] KIND_F64   = 4'd14;

    localparam int OUT_DEPTH = 4;

endpackage

>>> sv/ikl_scan.sv
`timescale 1ns / 1ps

module ikl_scan #(
    parameter longint unsigned TEXT_SIZE = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ikl_pkg::in_item_t item,
    output ikl_pkg::scan_out_t res
);
    import ikl_pkg::*;

    localparam int POS_W = $clog2(TEXT_SIZE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_SIZE - 64'd1);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_LETTER = 2'd2;
    localparam logic [1:0] MODE_DIGIT  = 2'd3;

    localparam logic [2:0] LC_U    = 3'd0;
    localparam logic [2:0] LC_S    = 3'd1;
    localparam logic [2:0] LC_B    = 3'd2;
    localparam logic [2:0] LC_F    = 3'd3;
    localparam logic [2:0] LC_NONE = 3'd4;

    localparam logic [1:0] DG_1 = 2'd0;
    localparam logic [1:0] DG_3 = 2'd1;
    localparam logic [1:0] DG_6 = 2'd2;

    localparam logic [1:0] W_8  = 2'd0;
    localparam logic [1:0] W_16 = 2'd1;
    localparam logic [1:0] W_32 = 2'd2;
    localparam logic [1:0] W_64 = 2'd3;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    function automatic logic is_ident_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [2:0] letter_class(input logic [7:0] c);
        logic [2:0] cls;
        priority if (c == "u") cls = LC_U;
        else if (c == "s")     cls = LC_S;
        else if (c == "b")     cls = LC_B;
        else if (c == "f")     cls = LC_F;
        else                   cls = LC_NONE;
        return cls;
    endfunction

    // Keyword code for a letter class and width class; identifier code when
    // the pair names no keyword (f8 and f16).
    function automatic logic [3:0] keyword_kind(input logic [1:0] cls, input logic [1:0] w);
        logic [3:0] kind;
        if (cls == LC_F[1:0]) begin
            kind = (w == W_32) ? KIND_F32 : ((w == W_64) ? KIND_F64 : KIND_IDENT);
        end else begin
            kind = {cls, w} + 4'd1;
        end
        return kind;
    endfunction

    function automatic token_t make_token(input logic [3:0] kind, input logic [15:0] start,
                                          input logic [15:0] len);
        token_t t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       letter_reg, letter_next;
    logic [1:0]       digit_reg, digit_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [POS_W+15:0] pos_wide;
    logic [15:0]       pos16;
    logic [7:0]        c;
    logic [2:0]        lc;
    logic              id_byte;
    logic              do_start;
    logic              do_flush;
    logic [1:0]        wcls;
    logic              wmatch;
    logic [3:0]        kind;
    logic              t0_valid, t1_valid;
    token_t            t0, t1;

    assign pos_wide = {16'd0, pos_reg};
    assign pos16    = pos_wide[15:0];
    assign c        = item.text_byte;
    assign lc       = letter_class(c);
    assign id_byte  = is_ident_byte(c);
    assign do_flush = (c == 8'd0) || item.is_final;

    always_comb
    begin
        mode_next   = mode_reg;
        letter_next = letter_reg;
        digit_next  = digit_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        do_start    = 1'b0;
        t0_valid    = 1'b0;
        t1_valid    = 1'b0;
        t0          = make_token(KIND_IDENT, start_reg, 16'd1);
        t1          = make_token(KIND_IDENT, start_reg, 16'd1);
        wcls        = W_8;
        wmatch      = 1'b0;
        kind        = KIND_IDENT;

        if (c != 8'd0)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    do_start = 1'b1;
                end
                MODE_IDENT:
                begin
                    if (id_byte)
                    begin
                        if (len_reg != LEN_MAX)
                            len_next = len_reg + 16'd1;
                    end
                    else
                    begin
                        t0_valid  = 1'b1;
                        t0        = make_token(KIND_IDENT, start_reg, len_reg);
                        mode_next = MODE_IDLE;
                        len_next  = 16'd0;
                    end
                end
                MODE_LETTER:
                begin
                    priority if (c == "8")
                    begin
                        kind      = keyword_kind(letter_reg, W_8);
                        t0_valid  = 1'b1;
                        t0        = make_token(kind, start_reg,
                                               (kind != KIND_IDENT) ? 16'd2 : 16'd1);
                        mode_next = MODE_IDLE;
                        len_next  = 16'd0;
                    end
                    else if (c == "1" || c == "3" || c == "6")
                    begin
                        mode_next  = MODE_DIGIT;
                        digit_next = (c == "1") ? DG_1 : ((c == "3") ? DG_3 : DG_6);
                    end
                    else if (id_byte)
                    begin
                        mode_next = MODE_IDENT;
                        len_next  = 16'd2;
                    end
                    else
                    begin
                        t0_valid  = 1'b1;
                        t0        = make_token(KIND_IDENT, start_reg, 16'd1);
                        mode_next = MODE_IDLE;
                        len_next  = 16'd0;
                    end
                end
                MODE_DIGIT:
                begin
                    priority if (digit_reg == DG_1 && c == "6")
                    begin
                        wcls   = W_16;
                        wmatch = 1'b1;
                    end
                    else if (digit_reg == DG_3 && c == "2")
                    begin
                        wcls   = W_32;
                        wmatch = 1'b1;
                    end
                    else if (digit_reg == DG_6 && c == "4")
                    begin
                        wcls   = W_64;
                        wmatch = 1'b1;
                    end
                    else
                    begin
                        wmatch = 1'b0;
                    end
                    kind      = wmatch ? keyword_kind(letter_reg, wcls) : KIND_IDENT;
                    t0_valid  = 1'b1;
                    mode_next = MODE_IDLE;
                    len_next  = 16'd0;
                    if (kind != KIND_IDENT)
                    begin
                        t0 = make_token(kind, start_reg, 16'd3);
                    end
                    else
                    begin
                        // The held letter stands alone; the breaking byte is rescanned.
                        t0       = make_token(KIND_IDENT, start_reg, 16'd1);
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (do_start)
            begin
                if (lc != LC_NONE)
                begin
                    mode_next   = MODE_LETTER;
                    letter_next = lc[1:0];
                    start_next  = pos16;
                    len_next    = 16'd1;
                end
                else if (id_byte)
                begin
                    mode_next  = MODE_IDENT;
                    start_next = pos16;
                    len_next   = 16'd1;
                end
            end

            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end

        if (do_flush)
        begin
            if (mode_next == MODE_IDENT)
            begin
                t1_valid = 1'b1;
                t1       = make_token(KIND_IDENT, start_next, len_next);
            end
            else if (mode_next == MODE_LETTER || mode_next == MODE_DIGIT)
            begin
                t1_valid = 1'b1;
                t1       = make_token(KIND_IDENT, start_next, 16'd1);
            end
            mode_next = MODE_IDLE;
            len_next  = 16'd0;
            pos_next  = '0;
        end
    end

    always_comb
    begin
        res.count  = {1'b0, t0_valid & step} + {1'b0, t1_valid & step};
        res.first  = t0_valid ? t0 : t1;
        res.second = t1;
        res.first.last_of_run  = !(t0_valid && t1_valid);
        res.second.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            letter_reg <= 2'd0;
            digit_reg  <= 2'd0;
            start_reg  <= 16'd0;
            len_reg    <= 16'd0;
            pos_reg    <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            letter_reg <= letter_next;
            digit_reg  <= digit_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

>>> sv/ikl_out_fifo.sv
`timescale 1ns / 1ps

module ikl_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  ikl_pkg::scan_out_t push,
    input  logic               pop,
    output logic               head_valid,
    output ikl_pkg::token_t    head,
    output logic               room_for_two
);
    import ikl_pkg::*;

    localparam int AW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    token_t        mem [OUT_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW-1:0] wr_ptr_plus1;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign head_valid   = (count_reg != '0);
    assign head         = mem[rd_ptr_reg];
    assign do_pop       = pop && head_valid;
    assign room_for_two = (count_reg <= CW'(OUT_DEPTH - 2));
    assign count_next   = count_reg + CW'(push.count) - CW'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push.count);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/ident_and_type_keyword_lexer.sv
`timescale 1ns / 1ps

// Identifier and type-keyword lexer.
// Source text enters on the byte channel (byte_valid, byte_stall, byte_item), one byte per
// transaction; a zero byte or is_final ends the text and flushes any pending token.
// Tokens leave on the token channel (token_valid, token_stall, token_item), one per
// transaction; last_of_run marks the final token that a given byte produced.
// Throughput is one byte per cycle while the queue has room for two tokens. A byte waits
// in the input register and is then classified against the scan state in a single pass;
// its tokens land in a four-entry result queue and are offered from its head. A byte can
// produce two tokens (a broken keyword followed by a flush) while the queue drains one per
// cycle when token_stall is low, so the byte channel stalls whenever a byte waits in the
// input register and the queue has fewer than two free entries; the queue depth sets how
// long a stalled receiver is absorbed. While token_stall is high the head token is held
// unchanged and bytes keep being taken until fewer than two queue entries are free. Reset
// clears the scan state, the byte offset and the queue; no transaction is to be offered or
// taken until rst_n is released, and the block itself does not enforce this for bytes.
module ident_and_type_keyword_lexer #(
    parameter longint unsigned TEXT_SIZE = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  ikl_pkg::in_item_t byte_item,
    output logic              token_valid,
    input  logic              token_stall,
    output ikl_pkg::token_t   token_item
);
    import ikl_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      room_for_two;
    logic      accept;
    logic      step;
    scan_out_t scan_res;

    // The input register is emptied whenever the queue can take a worst-case result pair.
    assign step       = in_valid_reg && room_for_two;
    assign byte_stall = in_valid_reg && !room_for_two;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= byte_item;
    end

    ikl_scan #(
        .TEXT_SIZE(TEXT_SIZE)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .res   (scan_res)
    );

    ikl_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (scan_res),
        .pop          (!token_stall),
        .head_valid   (token_valid),
        .head         (token_item),
        .room_for_two (room_for_two)
    );

endmodule

>>> sv/ikl_checker.sv
`timescale 1ns / 1ps

module ikl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_stall,
    input ikl_pkg::in_item_t byte_item,
    input logic              token_valid,
    input logic              token_stall,
    input ikl_pkg::token_t   token_item
);
    import ikl_pkg::*;

    // A stalled source byte must stay offered and unchanged.
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
        else $error("source byte changed while stalled");

    // A stalled token must stay offered and unchanged.
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_item))
        else $error("token changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> token_item.token_kind <= KIND_F64)
        else $error("token kind out of range");

    a_ident_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.token_kind == KIND_IDENT |-> token_item.token_length != 16'd0)
        else $error("empty identifier token");

    // Eight-bit keywords span two bytes; all others span three.
    a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.token_kind != KIND_IDENT |->
            ((token_item.token_kind == KIND_U8 || token_item.token_kind == KIND_S8 ||
              token_item.token_kind == KIND_B8) ? token_item.token_length == 16'd2
                                                : token_item.token_length == 16'd3))
        else $error("keyword token has wrong length");

endmodule

bind ident_and_type_keyword_lexer ikl_checker u_ikl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
);

>>> tb/ident_and_type_keyword_lexer_tb.sv
`timescale 1ns / 1ps

// Testbench for the identifier and type-keyword lexer.
// Source bytes go in on the byte channel, and every accepted byte is also run
// through a local lexer model that queues the tokens the block should produce.
// A monitor checks each accepted token against the oldest queued one.
module ident_and_type_keyword_lexer_tb;

    import ikl_pkg::*;

    // Scan states of the local model.
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_LETTER,
        SCAN_DIGIT
    } scan_mode_e;

    // Width part of a keyword. W_NONE means that the digits spell no width.
    typedef enum logic [2:0] {
        W8,
        W16,
        W32,
        W64,
        W_NONE
    } width_e;

    localparam logic [7:0] CH_U     = "u";
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_B     = "b";
    localparam logic [7:0] CH_F     = "f";
    localparam logic [7:0] CH_1     = "1";
    localparam logic [7:0] CH_2     = "2";
    localparam logic [7:0] CH_3     = "3";
    localparam logic [7:0] CH_4     = "4";
    localparam logic [7:0] CH_6     = "6";
    localparam logic [7:0] CH_8     = "8";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // A single identifier run long enough that its length needs more than
    // eight bits.
    localparam int LONG_RUN = 300;
    localparam int RANDOM_BYTES = 500;

    logic     clk;
    logic     rst_n;
    logic     byte_valid;
    logic     byte_stall;
    in_item_t byte_item;
    logic     token_valid;
    logic     token_stall;
    token_t   token_item;

    ident_and_type_keyword_lexer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token_item (token_item)
    );

    // Tokens that the model has predicted and the block has not yet delivered.
    token_t expected_tokens[$];

    // State of the local lexer model.
    scan_mode_e  lex_mode;
    logic [15:0] lex_pos;
    logic [15:0] lex_start;
    logic [15:0] lex_len;
    logic [7:0]  held_letter;
    logic [7:0]  held_digit;

    // Tokens found for the byte being modeled, in order.
    token_t step_tokens[2];
    int     step_count;

    // Idling controls shared by the sender and the token-side stall process.
    bit idle_on;
    int hold_request;
    int hold_left;
    int stall_left;

    int errors;
    int bytes_sent;
    int tokens_checked;
    int keywords_seen;
    int texts_ended;
    token_t head;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: ends the run if the traffic hangs.
    initial
    begin
        #10_000_000;
        $display("ident_and_type_keyword_lexer_tb failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want_v);
        $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want_v);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Local lexer model.
    // ------------------------------------------------------------------

    function automatic bit is_ident_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_keyword_letter(input logic [7:0] c);
        return c == CH_U || c == CH_S || c == CH_B || c == CH_F;
    endfunction

    // Kind of keyword that a letter and a width make, or KIND_IDENT if none.
    // Only f32 and f64 exist among the float widths.
    function automatic logic [3:0] keyword_code(input logic [7:0] letter, input width_e w);
        logic [3:0] offs;
        offs = {1'b0, w};
        case (letter)
            CH_U: return KIND_U8 + offs;
            CH_S: return KIND_S8 + offs;
            CH_B: return KIND_B8 + offs;
            CH_F:
            begin
                if (w == W32)
                    return KIND_F32;
                if (w == W64)
                    return KIND_F64;
                return KIND_IDENT;
            end
            default: return KIND_IDENT;
        endcase
    endfunction

    function automatic width_e width_of_pair(input logic [7:0] d1, input logic [7:0] d2);
        if (d1 == CH_1 && d2 == CH_6)
            return W16;
        if (d1 == CH_3 && d2 == CH_2)
            return W32;
        if (d1 == CH_6 && d2 == CH_4)
            return W64;
        return W_NONE;
    endfunction

    function automatic void note_token(input logic [3:0] kind, input logic [15:0] start,
                                       input logic [15:0] len);
        step_tokens[step_count].token_kind   = kind;
        step_tokens[step_count].token_start  = start;
        step_tokens[step_count].token_length = len;
        step_tokens[step_count].last_of_run  = 1'b0;
        step_count++;
    endfunction

    function automatic void scan_to_idle();
        lex_mode    = SCAN_IDLE;
        held_letter = CH_NUL;
        held_digit  = CH_NUL;
        lex_len     = 16'd0;
    endfunction

    // A byte seen between tokens: a keyword letter is held, any other
    // identifier character opens an identifier, everything else is skipped.
    function automatic void begin_token(input logic [7:0] c);
        if (is_keyword_letter(c))
        begin
            lex_mode    = SCAN_LETTER;
            held_letter = c;
            lex_start   = lex_pos;
            lex_len     = 16'd1;
        end
        else if (is_ident_char(c))
        begin
            lex_mode  = SCAN_IDENT;
            lex_start = lex_pos;
            lex_len   = 16'd1;
        end
    endfunction

    // Runs one accepted byte through the model and queues its tokens.
    function automatic void lex_predict(input logic [7:0] c, input logic fin);
        logic [3:0] kind;
        width_e     w;
        step_count = 0;
        if (c != CH_NUL)
        begin
            case (lex_mode)
                SCAN_IDENT:
                begin
                    if (is_ident_char(c))
                    begin
                        if (lex_len != LEN_MAX)
                            lex_len = lex_len + 16'd1;
                    end
                    else
                    begin
                        note_token(KIND_IDENT, lex_start, lex_len);
                        scan_to_idle();
                    end
                end
                SCAN_LETTER:
                begin
                    if (c == CH_8)
                    begin
                        // f8 is no keyword: the f stands alone and the 8 is dropped.
                        kind = keyword_code(held_letter, W8);
                        note_token(kind, lex_start, (kind != KIND_IDENT) ? 16'd2 : 16'd1);
                        scan_to_idle();
                    end
                    else if (c == CH_1 || c == CH_3 || c == CH_6)
                    begin
                        lex_mode   = SCAN_DIGIT;
                        held_digit = c;
                    end
                    else if (is_ident_char(c))
                    begin
                        lex_mode = SCAN_IDENT;
                        lex_len  = 16'd2;
                    end
                    else
                    begin
                        note_token(KIND_IDENT, lex_start, 16'd1);
                        scan_to_idle();
                    end
                end
                SCAN_DIGIT:
                begin
                    w    = width_of_pair(held_digit, c);
                    kind = (w != W_NONE) ? keyword_code(held_letter, w) : KIND_IDENT;
                    if (kind != KIND_IDENT)
                    begin
                        note_token(kind, lex_start, 16'd3);
                        scan_to_idle();
                    end
                    else
                    begin
                        // Broken keyword: the letter alone is an identifier, the held
                        // digit is dropped and this byte is looked at again.
                        note_token(KIND_IDENT, lex_start, 16'd1);
                        scan_to_idle();
                        begin_token(c);
                    end
                end
                default: begin_token(c);
            endcase
            lex_pos = lex_pos + 16'd1;
        end
        if (c == CH_NUL || fin)
        begin
            if (lex_mode == SCAN_IDENT)
                note_token(KIND_IDENT, lex_start, lex_len);
            else if (lex_mode == SCAN_LETTER || lex_mode == SCAN_DIGIT)
                note_token(KIND_IDENT, lex_start, 16'd1);
            lex_pos   = 16'd0;
            lex_start = 16'd0;
            scan_to_idle();
            texts_ended++;
        end
        if (step_count > 0)
            step_tokens[step_count - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_count; i++)
        begin
            if (step_tokens[i].token_kind != KIND_IDENT)
                keywords_seen++;
            expected_tokens.push_back(step_tokens[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte channel.
    // ------------------------------------------------------------------

    // Idle length before a byte: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one byte, holds it until the block takes it, then updates the model.
    // Valid is only lowered in a gap, so a back-to-back byte never sees a
    // low and a high assignment in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid          <= 1'b1;
        byte_item.text_byte <= b;
        byte_item.is_final  <= fin;
        forever
        begin
            @(posedge clk);
            if (byte_valid && !byte_stall)
                break;
        end
        lex_predict(b, fin);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_last && (i == s.len() - 1));
    endtask

    // ------------------------------------------------------------------
    // Token channel: random stall bursts plus long hold-offs on request.
    // The hold-off is counted here so that the sender keeps running.
    // ------------------------------------------------------------------
    initial
    begin
        token_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                token_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                token_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                         : $urandom_range(0, 2);
                token_stall <= 1'b1;
            end
            else
                token_stall <= 1'b0;
        end
    end

    // Token monitor: every accepted token must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("token with nothing expected, kind", token_item.token_kind,
                                KIND_IDENT);
            else
            begin
                head = expected_tokens.pop_front();
                if (token_item.token_kind !== head.token_kind)
                    report_mismatch("token_kind", token_item.token_kind, head.token_kind);
                if (token_item.token_start !== head.token_start)
                    report_mismatch("token_start", token_item.token_start, head.token_start);
                if (token_item.token_length !== head.token_length)
                    report_mismatch("token_length", token_item.token_length,
                                    head.token_length);
                if (token_item.last_of_run !== head.last_of_run)
                    report_mismatch("last_of_run", token_item.last_of_run, head.last_of_run);
                tokens_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Corner cases: f8 and f16, a broken keyword whose breaking byte starts a
    // new identifier, a held letter and a held digit cut off by the end of
    // text, both ways of ending a text, and the byte extremes.
    task automatic test_special_cases();
        send_text("f8f16", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_text("u6x", 1'b0);
        send_byte(CH_S, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_text("Z_Az", 1'b0);
        send_byte(8'h80, 1'b1);
        send_text("b64", 1'b1);
        send_text("s3", 1'b1);
        send_byte(CH_U, 1'b1);
        send_byte(CH_NUL, 1'b1);
    endtask

    // All fourteen keywords, an uppercase lookalike and keywords run together.
    task automatic test_keywords();
        send_text("u8 u16 u32 u64 s8 s16 s32 s64 b8 b16 b32 b64 f32 f64 U8 u8u16f64", 1'b1);
    endtask

    // A long identifier sent back to back: its length runs past eight bits,
    // and the keyword that follows starts at a wide byte offset.
    task automatic test_long_text();
        idle_on = 1'b0;
        for (int i = 0; i < LONG_RUN; i++)
            send_byte(8'("a" + (i % 26)), 1'b0);
        send_text(" u8", 1'b1);
        idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while single-letter
    // identifiers are offered back to back, so the block must stall its input.
    task automatic test_pressure();
        idle_on      = 1'b0;
        hold_request = 80;
        for (int i = 0; i < 40; i++)
            send_byte((i % 2 == 0) ? 8'("a" + (i % 26)) : CH_SPACE, 1'b0);
        send_byte(CH_SPACE, 1'b1);
        idle_on = 1'b1;
    endtask

    function automatic logic [7:0] rand_ident_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + (r - 26));
        return "_";
    endfunction

    function automatic logic [7:0] rand_separator();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return is_ident_char(c) ? CH_SPACE : c;
    endfunction

    // Random text built mostly from well-formed pieces: keywords, identifiers
    // and broken keywords with random content, mixed with separators, raw noise
    // and occasional ends of text. Idling is switched off for some stretches.
    task automatic test_random();
        logic [7:0] piece[$];
        logic [7:0] letters[4];
        int         start_count;
        int         pick;
        int         n;
        bit         fin_last;
        letters     = '{CH_U, CH_S, CH_B, CH_F};
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            piece.delete();
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                piece.push_back(letters[$urandom_range(0, 3)]);
                case ($urandom_range(0, 3))
                    0: piece.push_back(CH_8);
                    1: begin piece.push_back(CH_1); piece.push_back(CH_6); end
                    2: begin piece.push_back(CH_3); piece.push_back(CH_2); end
                    default: begin piece.push_back(CH_6); piece.push_back(CH_4); end
                endcase
            end
            else if (pick < 55)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    piece.push_back(rand_ident_char());
            end
            else if (pick < 65)
            begin
                piece.push_back(letters[$urandom_range(0, 3)]);
                case ($urandom_range(0, 2))
                    0: piece.push_back(CH_1);
                    1: piece.push_back(CH_3);
                    default: piece.push_back(CH_6);
                endcase
                piece.push_back(8'($urandom_range(1, 255)));
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    piece.push_back(rand_separator());
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    piece.push_back(8'($urandom_range(1, 255)));
            end
            pick     = $urandom_range(0, 99);
            fin_last = (pick < 4);
            for (int i = 0; i < piece.size(); i++)
                send_byte(piece[i], fin_last && (i == piece.size() - 1));
            if (pick >= 4 && pick < 8)
                send_byte(CH_NUL, 1'($urandom_range(0, 1)));
        end
        send_byte(CH_NUL, 1'b1);
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_item      = '0;
        idle_on        = 1'b1;
        hold_request   = 0;
        hold_left      = 0;
        stall_left     = 0;
        errors         = 0;
        bytes_sent     = 0;
        tokens_checked = 0;
        keywords_seen  = 0;
        texts_ended    = 0;
        lex_pos        = 16'd0;
        lex_start      = 16'd0;
        step_count     = 0;
        scan_to_idle();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_keywords();
        test_pressure();
        test_long_text();
        test_random();

        @(negedge clk);
        byte_valid <= 1'b0;

        // Wait for the last predicted token, then keep the clock running so that a
        // stray extra token would still be seen. The watchdog bounds the wait.
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_tokens.size() != 0)
            report_mismatch("tokens never delivered", 0, expected_tokens.size());

        $display("Run covered %0d source bytes in %0d texts and checked %0d tokens (%0d keywords).",
                 bytes_sent, texts_ended, tokens_checked, keywords_seen);
        $display("It included f8/f16, broken keywords, a long identifier run "
                 , "and a long receiver hold-off.");
        if (errors == 0)
            $display("ident_and_type_keyword_lexer_tb passed");
        else
            $display("ident_and_type_keyword_lexer_tb failed");
        $finish;
    end

endmodule
